### hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
// No dependencies; pulled in with `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the async reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

### hw/rtl/lsra_pkg.sv
// Shared types and constants for the linear scan register assigner.
// No dependencies; used by lsra_ctrl, lsra_dp and the top level.
package lsra_pkg;

	localparam int NUM_PHYS_DEF   = 10;
	localparam int POINT_BITS_DEF = 16;

	localparam int MASK_BITS  = 10;
	localparam int ID_BITS    = 16;
	localparam int FIELD_BITS = 16;
	localparam int SPILL_BITS = 16;
	localparam int IDX_BITS   = 4;

	localparam logic [MASK_BITS-1:0]  MASK_RESET = '1;
	localparam logic [SPILL_BITS-1:0] SPILL_MAX  = '1;

	// occupancy of the output register
	typedef enum logic {
		OUT_EMPTY,
		OUT_FULL
	} out_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // commit this word: update state and output register
		logic restart;  // new function: start from empty busy set and zero spills
	} cmd_t;

endpackage

### hw/rtl/linear_scan_register_assigner_unit.sv
// An accepted word is registered and presented on the output in the cycle after it is accepted.
// Throughput: one word per cycle; the free/pick compare bank and the priority pick
// settle in the accept cycle and load the single output register.
// Input is stalled only while the output register is full and the consumer stalls.
// Reset (arst_n low, async): busy set and spill counter cleared, available mask all
// ones, output register empty. Depends on lsra_pkg, lsra_ctrl and lsra_dp.
module linear_scan_register_assigner_unit #(
	parameter int NUM_PHYS   = lsra_pkg::NUM_PHYS_DEF,
	parameter int POINT_BITS = lsra_pkg::POINT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: available register mask
	input  logic                              cfg_we,
	input  logic [lsra_pkg::MASK_BITS-1:0]    cfg_wdata,
	// interval words in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              new_function,
	input  logic [lsra_pkg::ID_BITS-1:0]      vreg_id,
	input  logic [lsra_pkg::FIELD_BITS-1:0]   start_point,
	input  logic [lsra_pkg::FIELD_BITS-1:0]   end_point,
	// assignment words out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lsra_pkg::ID_BITS-1:0]      vreg_out,
	output logic                              spilled,
	output logic [lsra_pkg::IDX_BITS-1:0]     phys_index,
	output logic [lsra_pkg::SPILL_BITS-1:0]   spill_slot
);

	// The controller owns the handshake; every accepted word turns into one
	// load command. On load the datapath:
	//   - starts from an empty busy set and zero spills if new_function is set,
	//   - frees each busy register whose stored end lies below start_point,
	//   - grants the lowest free register enabled in the mask,
	//   - otherwise hands out the current spill slot (saturating at all ones).
	// Spilled words occupy no register.
	lsra_pkg::cmd_t cmd;

	lsra_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.new_function (new_function),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd          (cmd)
	);

	lsra_dp #(
		.NUM_PHYS   (NUM_PHYS),
		.POINT_BITS (POINT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.vreg_id     (vreg_id),
		.start_point (start_point),
		.end_point   (end_point),
		.vreg_out    (vreg_out),
		.spilled     (spilled),
		.phys_index  (phys_index),
		.spill_slot  (spill_slot)
	);

endmodule

### hw/rtl/lsra_ctrl.sv
// Handshake controller: tracks the output register and issues load commands.
// Depends on lsra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsra_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             new_function,
	output logic             out_valid,
	input  logic             out_stall,
	output lsra_pkg::cmd_t   cmd
);

	lsra_pkg::out_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsra_pkg::OUT_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		out_valid   = (state_q == lsra_pkg::OUT_FULL);
		in_stall    = out_valid && out_stall;
		cmd.load    = in_valid && !in_stall;
		cmd.restart = cmd.load && new_function;
		state_d     = state_q;
		case (state_q)
			lsra_pkg::OUT_EMPTY: begin
				if (cmd.load) state_d = lsra_pkg::OUT_FULL;
			end
			lsra_pkg::OUT_FULL: begin
				if (!cmd.load && !out_stall) state_d = lsra_pkg::OUT_EMPTY;
			end
			default: state_d = lsra_pkg::OUT_EMPTY;
		endcase
	end

	`ASSERT_CLK(a_load_fills, clk, arst_n, cmd.load |=> out_valid, "loaded word not presented")
	`ASSERT_CLK(a_hold_full, clk, arst_n, (out_valid && out_stall) |=> out_valid, "stalled word dropped")

endmodule

### hw/rtl/lsra_dp.sv
// Datapath: busy set, end points, spill counter, free/pick logic, output register.
// Depends on lsra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsra_dp #(
	parameter int NUM_PHYS   = lsra_pkg::NUM_PHYS_DEF,
	parameter int POINT_BITS = lsra_pkg::POINT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsra_pkg::cmd_t                    cmd,
	input  logic                              cfg_we,
	input  logic [lsra_pkg::MASK_BITS-1:0]    cfg_wdata,
	input  logic [lsra_pkg::ID_BITS-1:0]      vreg_id,
	input  logic [lsra_pkg::FIELD_BITS-1:0]   start_point,
	input  logic [lsra_pkg::FIELD_BITS-1:0]   end_point,
	output logic [lsra_pkg::ID_BITS-1:0]      vreg_out,
	output logic                              spilled,
	output logic [lsra_pkg::IDX_BITS-1:0]     phys_index,
	output logic [lsra_pkg::SPILL_BITS-1:0]   spill_slot
);

	// only registers below both the mask width and NUM_PHYS can be granted
	localparam int EFF = (NUM_PHYS < lsra_pkg::MASK_BITS) ? NUM_PHYS : lsra_pkg::MASK_BITS;
	localparam int PB_IN = (POINT_BITS < lsra_pkg::FIELD_BITS) ? POINT_BITS
	                                                          : lsra_pkg::FIELD_BITS;

	logic [lsra_pkg::MASK_BITS-1:0]  avail_q;
	logic [NUM_PHYS-1:0]             busy_q;
	logic [POINT_BITS-1:0]           end_q [NUM_PHYS];
	logic [lsra_pkg::SPILL_BITS-1:0] spill_cnt_q;

	logic [POINT_BITS-1:0]           start_pt, end_pt;
	logic [NUM_PHYS-1:0]             busy_base, busy_kept, avail_ext, usable, grant;
	logic [lsra_pkg::SPILL_BITS-1:0] spill_base, spill_next;
	logic [lsra_pkg::IDX_BITS-1:0]   pick;
	logic                            found;

	always_comb begin
		start_pt = '0;
		end_pt   = '0;
		for (int k = 0; k < PB_IN; k++) begin
			start_pt[k] = start_point[k];
			end_pt[k]   = end_point[k];
		end
	end

	always_comb begin
		busy_base  = cmd.restart ? '0 : busy_q;
		spill_base = cmd.restart ? '0 : spill_cnt_q;
		// release every occupant whose interval ended before this start
		for (int i = 0; i < NUM_PHYS; i++) begin
			busy_kept[i] = busy_base[i] && !(end_q[i] < start_pt);
		end
		avail_ext = '0;
		for (int i = 0; i < EFF; i++) begin
			avail_ext[i] = avail_q[i];
		end
		usable = ~busy_kept & avail_ext;
		grant  = usable & (~usable + 1'b1);
		found  = |usable;
		pick   = '0;
		for (int i = EFF - 1; i >= 0; i--) begin
			if (usable[i]) pick = lsra_pkg::IDX_BITS'(i);
		end
		spill_next = (spill_base != lsra_pkg::SPILL_MAX) ? spill_base + 1'b1 : spill_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q     <= lsra_pkg::MASK_RESET;
			busy_q      <= '0;
			spill_cnt_q <= '0;
		end else begin
			if (cfg_we) avail_q <= cfg_wdata;
			if (cmd.load) begin
				busy_q      <= busy_kept | grant;
				// a restart clears the count even when a register is granted
				spill_cnt_q <= found ? spill_base : spill_next;
			end
		end
	end

	// end points and result word carry no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_PHYS; i++) begin
			if (cmd.load && grant[i]) end_q[i] <= end_pt;
		end
		if (cmd.load) begin
			vreg_out   <= vreg_id;
			spilled    <= !found;
			phys_index <= found ? pick : '0;
			spill_slot <= found ? '0 : spill_base;
		end
	end

	`ASSERT_CLK(a_grant_onehot, clk, arst_n, $onehot0(grant), "more than one register granted")
	`ASSERT_CLK(a_spill_mono, clk, arst_n,
		(cmd.load && !cmd.restart) |=> (spill_cnt_q >= $past(spill_cnt_q)), "spill count fell")
	`ASSERT_NEVER(a_busy_range, clk, arst_n,
		(EFF < NUM_PHYS) && ((busy_q >> EFF) != '0), "register beyond mask marked busy")

endmodule
